### hdl/indent_dedent_token_generator_defines.svh
// Assertion macros for the indentation token generator.
// Needs clk and arst_n in the scope of use; no other dependencies.
`ifndef INDENT_DEDENT_TOKEN_GENERATOR_DEFINES_SVH
`define INDENT_DEDENT_TOKEN_GENERATOR_DEFINES_SVH

// same-cycle implication
`define IDTG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDTG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/idtg_pkg.sv
// Shared types and token codes for the indentation token generator.
// No dependencies.
package idtg_pkg;

	localparam int IN_LEN_W = 16;
	localparam int TOK_W    = 2;

	localparam logic [TOK_W-1:0] TOK_NONE    = 2'd0;
	localparam logic [TOK_W-1:0] TOK_NEWLINE = 2'd1;
	localparam logic [TOK_W-1:0] TOK_INDENT  = 2'd2;
	localparam logic [TOK_W-1:0] TOK_DEDENT  = 2'd3;

	typedef struct packed {
		logic line_end;
		logic dot;
		logic w_nl;
		logic w_in;
		logic w_de;
		logic w_lit;
	} req_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_cmd_t;

	typedef struct packed {
		logic full;
		logic multi;
	} stack_stat_t;

	typedef struct packed {
		logic [TOK_W-1:0] kind;
		logic             ovf;
	} result_t;

endpackage

### hdl/idtg_stack.sv
// Indentation stack: cached top, one-write one-read memory, registered read of the entry below.
// Depends on idtg_pkg and the defines header.
`include "indent_dedent_token_generator_defines.svh"
module idtg_stack #(
	parameter int STACK_DEPTH = 32,
	parameter int INDENT_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  idtg_pkg::stack_cmd_t    cmd,
	input  logic [INDENT_BITS-1:0]  wdata,
	output idtg_pkg::stack_stat_t   stat,
	output logic [INDENT_BITS-1:0]  top,
	output logic [INDENT_BITS-1:0]  below
);
	import idtg_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [INDENT_BITS-1:0] mem [STACK_DEPTH];
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_d;
	logic [INDENT_BITS-1:0] top_q;
	logic [INDENT_BITS-1:0] rd_q;
	logic                   rd_zero_q;
	logic [CW-1:0]          raddr_w;

	assign stat.full  = (count_q == CW'(STACK_DEPTH));
	assign stat.multi = (count_q > CW'(1));
	assign top        = top_q;
	assign below      = rd_zero_q ? '0 : rd_q;

	always_comb begin
		count_d = count_q;
		if (cmd.push && !stat.full) begin
			count_d = count_q + CW'(1);
		end else if (cmd.pop && stat.multi) begin
			count_d = count_q - CW'(1);
		end
		raddr_w = (count_d > CW'(1)) ? (count_d - CW'(2)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= CW'(1);
			top_q     <= '0;
			rd_zero_q <= 1'b1;
		end else begin
			count_q   <= count_d;
			// entry below is the base level while two or fewer entries are held
			rd_zero_q <= (count_d < CW'(3));
			if (cmd.push && !stat.full) begin
				top_q <= wdata;
			end else if (cmd.pop && stat.multi) begin
				top_q <= below;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !stat.full) begin
			mem[count_q[AW-1:0]] <= wdata;
		end
		rd_q <= mem[raddr_w[AW-1:0]];
	end

	`IDTG_ASSERT_NOW(a_no_push_full, cmd.push, !stat.full, "push into full stack")
	`IDTG_ASSERT_NEXT(a_push_top, cmd.push && !stat.full, top_q == $past(wdata), "push lost")
	`IDTG_ASSERT_NEXT(a_base_pop, cmd.pop && !stat.multi, $stable(top_q) && $stable(count_q), "base popped")

endmodule

### hdl/idtg_ctrl.sv
// Token decision for one item and the pending dedent width.
// Depends on idtg_pkg; reads the stack top and the entry below it.
module idtg_ctrl #(
	parameter int INDENT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  idtg_pkg::req_t                  req,
	input  logic [idtg_pkg::IN_LEN_W-1:0]   len_raw,
	input  idtg_pkg::stack_stat_t           stat,
	input  logic [INDENT_BITS-1:0]          top,
	input  logic [INDENT_BITS-1:0]          below,
	output idtg_pkg::stack_cmd_t            cmd,
	output logic [INDENT_BITS-1:0]          len,
	output idtg_pkg::result_t               res
);
	import idtg_pkg::*;

	localparam logic [IN_LEN_W:0] IMAX = (IN_LEN_W+1)'((1 << INDENT_BITS) - 1);

	logic [INDENT_BITS-1:0] pend_w_q;
	logic                   pend_v_q;
	logic                   pend_set;
	logic                   pend_clr;
	logic [INDENT_BITS-1:0] new_top;

	assign len     = ({1'b0, len_raw} > IMAX) ? '1 : len_raw[INDENT_BITS-1:0];
	assign new_top = stat.multi ? below : top;

	always_comb begin
		res.kind = TOK_NONE;
		res.ovf  = 1'b0;
		cmd      = '0;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		if (pend_v_q && req.w_de && pend_w_q < top) begin
			cmd.pop  = 1'b1;
			res.kind = TOK_DEDENT;
		end else begin
			pend_clr = pend_v_q;
			priority if (req.w_lit && !req.w_nl && !req.w_in && !req.w_de) begin
				res.kind = TOK_NONE;
			end else if (!req.line_end) begin
				res.kind = TOK_NONE;
			end else if (req.dot && len == top && !req.w_in) begin
				res.kind = TOK_NONE;
			end else if (req.w_in && len > top) begin
				res.kind = TOK_INDENT;
				if (stat.full) begin
					res.ovf = 1'b1;
				end else begin
					cmd.push = 1'b1;
				end
			end else if (req.w_de && len < top) begin
				res.kind = TOK_DEDENT;
				cmd.pop  = 1'b1;
				pend_set = (len < new_top);
			end else if (req.w_nl) begin
				res.kind = TOK_NEWLINE;
				pend_set = (len != top);
			end else begin
				res.kind = TOK_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_w_q <= '0;
		end else if (adv) begin
			if (pend_set) begin
				pend_v_q <= 1'b1;
				pend_w_q <= len;
			end else if (pend_clr) begin
				pend_v_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/idtg_outbuf.sv
// Result register with one skid entry.
// Depends on idtg_pkg and the defines header.
`include "indent_dedent_token_generator_defines.svh"
module idtg_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  idtg_pkg::result_t   din,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output idtg_pkg::result_t   dout
);
	import idtg_pkg::*;

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    drain;

	assign drain     = out_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign dout      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (drain) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || drain) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (drain) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (drain) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_v_q || drain) begin
				out_q <= din;
			end else begin
				skid_q <= din;
			end
		end
	end

	`IDTG_ASSERT_NOW(a_skid_implies_out, skid_v_q, out_v_q, "skid holds data with empty output")
	`IDTG_ASSERT_NEXT(a_skid_drains, skid_v_q && drain, out_v_q && !skid_v_q, "skid not moved")
	`IDTG_ASSERT_NEXT(a_skid_fill, push && out_v_q && !drain && !skid_v_q, skid_v_q, "transfer lost")

endmodule

### hdl/indent_dedent_token_generator.sv
// Result path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while item_stall is low (result skid entry not full); set
// by one compare against the cached stack top and a one-write one-read stack memory whose
// registered read holds the entry below the top.
// Reset (arst_n low, asynchronous): stack holds only the base level 0, no pending dedent,
// all channels empty. No clearing pass; memory entries are read only after they are written.
module indent_dedent_token_generator #(
	parameter int STACK_DEPTH = 32,
	parameter int INDENT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          line_end_seen,
	input  logic [idtg_pkg::IN_LEN_W-1:0] next_indent,
	input  logic                          starts_with_dot,
	input  logic                          want_newline,
	input  logic                          want_indent,
	input  logic                          want_dedent,
	input  logic                          want_literal,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [idtg_pkg::TOK_W-1:0]    token_kind,
	output logic                          stack_overflow
);
	import idtg_pkg::*;

	logic                   v_s1;
	req_t                   req_s1;
	logic [IN_LEN_W-1:0]    len_s1;
	logic                   adv;
	logic                   buf_full;
	stack_cmd_t             cmd;
	stack_stat_t            stat;
	logic [INDENT_BITS-1:0] top;
	logic [INDENT_BITS-1:0] below;
	logic [INDENT_BITS-1:0] len_sat;
	result_t                res;
	result_t                res_out;

	assign adv        = v_s1 && !buf_full;
	assign item_stall = v_s1 && buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			req_s1.line_end <= line_end_seen;
			req_s1.dot      <= starts_with_dot;
			req_s1.w_nl     <= want_newline;
			req_s1.w_in     <= want_indent;
			req_s1.w_de     <= want_dedent;
			req_s1.w_lit    <= want_literal;
			len_s1          <= next_indent;
		end
	end

	idtg_ctrl #(
		.INDENT_BITS(INDENT_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.req(req_s1),
		.len_raw(len_s1),
		.stat(stat),
		.top(top),
		.below(below),
		.cmd(cmd),
		.len(len_sat),
		.res(res)
	);

	stack_cmd_t cmd_gated;
	assign cmd_gated.push = cmd.push && adv;
	assign cmd_gated.pop  = cmd.pop && adv;

	idtg_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.INDENT_BITS(INDENT_BITS)
	) u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_gated),
		.wdata(len_sat),
		.stat(stat),
		.top(top),
		.below(below)
	);

	idtg_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(adv),
		.din(res),
		.full(buf_full),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.dout(res_out)
	);

	assign token_kind     = res_out.kind;
	assign stack_overflow = res_out.ovf;

endmodule

### tb/sv/indent_dedent_token_generator_checker.sv
// Checker for the indentation token generator: follows the item and result channels.
// It keeps its own indentation stack, predicts one token per item and compares results.
// Depends on idtg_pkg for the token codes and the result struct.
module indent_dedent_token_generator_checker #(
	parameter int STACK_DEPTH = 32,
	parameter int INDENT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic                          line_end_seen,
	input  logic [idtg_pkg::IN_LEN_W-1:0] next_indent,
	input  logic                          starts_with_dot,
	input  logic                          want_newline,
	input  logic                          want_indent,
	input  logic                          want_dedent,
	input  logic                          want_literal,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [idtg_pkg::TOK_W-1:0]    token_kind,
	input  logic                          stack_overflow,
	output int                            failures,
	output int                            outstanding
);
	import idtg_pkg::*;

	localparam logic [IN_LEN_W-1:0] LEN_MAX = IN_LEN_W'((32'd1 << INDENT_BITS) - 1);

	logic [IN_LEN_W-1:0] levels [STACK_DEPTH];
	int                  depth;
	logic [IN_LEN_W-1:0] pend_width;
	logic                pend_valid;
	result_t             expected_tokens [$];
	result_t             predicted;
	result_t             oldest;

	function automatic result_t next_token(input logic le, input logic [IN_LEN_W-1:0] raw,
			input logic dot, input logic nl, input logic ind, input logic de, input logic lit);
		result_t             r;
		logic [IN_LEN_W-1:0] len;
		logic [IN_LEN_W-1:0] top;
		r.kind = TOK_NONE;
		r.ovf  = 1'b0;
		len = (raw > LEN_MAX) ? LEN_MAX : raw;
		top = levels[depth-1];
		if (pend_valid) begin
			if (de && pend_width < top) begin
				if (depth > 1)
					depth--;
				r.kind = TOK_DEDENT;
				return r;
			end
			pend_valid = 1'b0;
		end
		if (lit && !nl && !ind && !de)
			return r;
		if (!le)
			return r;
		// dot chaining: continuation line at the current level
		if (dot && len == top && !ind)
			return r;
		if (ind && len > top) begin
			if (depth >= STACK_DEPTH) begin
				r.ovf = 1'b1;
			end else begin
				levels[depth] = len;
				depth++;
			end
			r.kind = TOK_INDENT;
			return r;
		end
		if (de && len < top) begin
			if (depth > 1)
				depth--;
			if (len < levels[depth-1]) begin
				pend_width = len;
				pend_valid = 1'b1;
			end
			r.kind = TOK_DEDENT;
			return r;
		end
		if (nl) begin
			if (len != top) begin
				pend_width = len;
				pend_valid = 1'b1;
			end
			r.kind = TOK_NEWLINE;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++)
				levels[i] = '0;
			depth = 1;
			pend_width = '0;
			pend_valid = 1'b0;
			expected_tokens.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			if (item_valid && !item_stall) begin
				predicted = next_token(line_end_seen, next_indent, starts_with_dot,
					want_newline, want_indent, want_dedent, want_literal);
				expected_tokens.push_back(predicted);
			end
			if (result_valid && !result_stall) begin
				if (expected_tokens.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("token check: unexpected transfer, kind %0d ovf %0d",
							token_kind, stack_overflow);
				end else begin
					oldest = expected_tokens.pop_front();
					if (token_kind !== oldest.kind || stack_overflow !== oldest.ovf) begin
						failures++;
						if (failures <= 10)
							$display("token check: expected kind %0d ovf %0d, got kind %0d ovf %0d",
								oldest.kind, oldest.ovf, token_kind, stack_overflow);
					end
				end
			end
			outstanding = expected_tokens.size();
		end
	end

endmodule

### tb/sv/indent_dedent_token_generator_test.sv
// Testbench top for the indentation token generator: clock, reset, scanner calls, verdict.
// Drives directed and random call sequences under varying idle and stall rates.
// Depends on indent_dedent_token_generator and indent_dedent_token_generator_checker.
module indent_dedent_token_generator_test;
	import idtg_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	logic                line_end_seen;
	logic [IN_LEN_W-1:0] next_indent;
	logic                starts_with_dot;
	logic                want_newline;
	logic                want_indent;
	logic                want_dedent;
	logic                want_literal;
	logic                result_valid;
	logic                result_stall;
	logic [TOK_W-1:0]    token_kind;
	logic                stack_overflow;
	int                  failures;
	int                  outstanding;

	int calls_sent = 0;
	int tx_idle_pct = 24;
	int rx_idle_pct = 81;
	int hold_requests = 0;

	always #5 clk = ~clk;

	indent_dedent_token_generator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.line_end_seen  (line_end_seen),
		.next_indent    (next_indent),
		.starts_with_dot(starts_with_dot),
		.want_newline   (want_newline),
		.want_indent    (want_indent),
		.want_dedent    (want_dedent),
		.want_literal   (want_literal),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.token_kind     (token_kind),
		.stack_overflow (stack_overflow)
	);

	indent_dedent_token_generator_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.line_end_seen  (line_end_seen),
		.next_indent    (next_indent),
		.starts_with_dot(starts_with_dot),
		.want_newline   (want_newline),
		.want_indent    (want_indent),
		.want_dedent    (want_dedent),
		.want_literal   (want_literal),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.token_kind     (token_kind),
		.stack_overflow (stack_overflow),
		.failures       (failures),
		.outstanding    (outstanding)
	);

	task automatic send_call(input logic le, input logic [IN_LEN_W-1:0] len, input logic dot,
			input logic nl, input logic ind, input logic de, input logic lit);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid      <= 1'b1;
		line_end_seen   <= le;
		next_indent     <= len;
		starts_with_dot <= dot;
		want_newline    <= nl;
		want_indent     <= ind;
		want_dedent     <= de;
		want_literal    <= lit;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		calls_sent++;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin
		#3000000;
		$display("indent_dedent_token_generator_test: FAIL");
		$finish;
	end

	initial begin
		int                  n;
		int                  guard;
		bit                  held;
		logic [IN_LEN_W-1:0] w;
		logic [IN_LEN_W-1:0] len;
		held = 1'b0;
		w = '0;
		arst_n          <= 1'b0;
		item_valid      <= 1'b0;
		line_end_seen   <= 1'b0;
		next_indent     <= '0;
		starts_with_dot <= 1'b0;
		want_newline    <= 1'b0;
		want_indent     <= 1'b0;
		want_dedent     <= 1'b0;
		want_literal    <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: le, len, dot, nl, ind, de, lit
		send_call(1, 0, 0, 1, 0, 0, 0);
		send_call(0, 4, 0, 1, 1, 1, 0);
		send_call(1, 4, 0, 0, 1, 0, 0);
		send_call(1, 8, 0, 0, 1, 0, 0);
		send_call(1, 8, 1, 1, 0, 1, 0);
		send_call(1, 8, 1, 0, 1, 0, 0);
		send_call(1, 4, 0, 0, 0, 0, 1);
		send_call(1, 0, 0, 1, 0, 0, 0);
		send_call(1, 0, 0, 0, 0, 1, 0);
		send_call(1, 0, 0, 0, 0, 1, 0);
		send_call(1, 0, 0, 0, 0, 1, 0);
		send_call(1, 16'hFFFF, 0, 0, 1, 0, 1);
		send_call(1, 16'hFFFF, 0, 1, 1, 1, 1);
		send_call(1, 3, 0, 0, 0, 1, 0);
		send_call(1, 2, 0, 1, 0, 0, 0);
		send_call(1, 1, 0, 0, 0, 1, 0);
		send_call(1, 0, 0, 0, 0, 1, 0);
		send_call(1, 5, 0, 0, 0, 0, 0);
		send_call(1, 10, 0, 0, 1, 0, 0);
		send_call(1, 20, 0, 0, 1, 0, 0);
		send_call(1, 30, 0, 0, 1, 0, 0);
		send_call(1, 5, 0, 0, 0, 1, 0);
		send_call(1, 5, 0, 1, 0, 1, 0);
		send_call(1, 5, 0, 1, 1, 0, 0);
		send_call(1, 5, 0, 0, 0, 0, 0);

		while (calls_sent < 675) begin
			if (calls_sent < 260) begin
				tx_idle_pct = 24;
				rx_idle_pct = 81;
			end else if (calls_sent < 480) begin
				tx_idle_pct = 81;
				rx_idle_pct = 24;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				if (!held) begin
					held = 1'b1;
					hold_requests++;
				end
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// nesting run, sometimes deep enough to fill the stack
					n = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
					repeat (n) begin
						len = (w > 16'hFFF7) ? 16'hFFFF : w + IN_LEN_W'($urandom_range(1, 8));
						send_call(1, len, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 1,
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
						w = len;
					end
				end
				3, 4: begin
					// dedent, then follow-up calls to drain pending levels
					len = IN_LEN_W'($urandom_range(0, w));
					send_call(1, len, 0, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, 1,
						1'($urandom_range(0, 1)));
					repeat ($urandom_range(0, 6))
						send_call($urandom_range(0, 3) != 0, len, 0, 1'($urandom_range(0, 1)), 0,
							$urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)));
					w = len;
				end
				5, 6: begin
					repeat ($urandom_range(1, 6)) begin
						case ($urandom_range(0, 3))
							0, 1: len = w;
							2: len = IN_LEN_W'($urandom_range(0, w));
							default: len = (w > 16'hFFFB) ? 16'hFFFF : w + IN_LEN_W'($urandom_range(1, 4));
						endcase
						send_call(1, len, 1'($urandom_range(0, 1)), 1, $urandom_range(0, 3) == 0,
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					end
				end
				7: begin
					send_call(1'($urandom_range(0, 1)), w, 1'($urandom_range(0, 1)), 0, 0, 0, 1);
				end
				default: begin
					send_call(1'($urandom_range(0, 1)), IN_LEN_W'($urandom),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				end
			endcase
		end

		item_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (outstanding != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("indent_dedent_token_generator_test: PASS");
		else
			$display("indent_dedent_token_generator_test: FAIL");
		$finish;
	end

endmodule
